// ===== rtl/nic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_pkg
// Shared types, codes and format tables for the normalized integer / float
// converter.
// ----------------------------------------------------------------------------
package nic_pkg;

  // Integer format codes
  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_U16 = 2'd1,
    FMT_S8  = 2'd2,
    FMT_S16 = 2'd3
  } fmt_t;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_FORMAT    = 8'd0,
    REG_DIRECTION = 8'd1
  } reg_idx_t;

  localparam int CFG_IDX_W = 8;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;

  // Unpack operand class
  typedef enum logic [1:0] {
    UK_NORM,
    UK_ZERO,
    UK_ONE,
    UK_CLAMP
  } ukind_t;

  // Pack operand class (infinity rides with the overflow path)
  typedef enum logic [1:0] {
    PK_NORM,
    PK_ZERO,
    PK_NAN
  } pkind_t;

  // One result beat of a datapath
  typedef struct packed {
    logic [31:0] raw;
    logic        sat;
  } res_t;

  // Format maximum, 2^k - 1
  function automatic logic [15:0] fmt_max(fmt_t f);
    logic [15:0] m;
    case (f)
      FMT_U8:  m = 16'd255;
      FMT_U16: m = 16'd65535;
      FMT_S8:  m = 16'd127;
      FMT_S16: m = 16'd32767;
      default: m = 16'd255;
    endcase
    return m;
  endfunction

  // Magnitude bit count k of the format maximum
  function automatic logic [4:0] fmt_bits(fmt_t f);
    logic [4:0] k;
    case (f)
      FMT_U8:  k = 5'd8;
      FMT_U16: k = 5'd16;
      FMT_S8:  k = 5'd7;
      FMT_S16: k = 5'd15;
      default: k = 5'd8;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/nic_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_unpack
// Integer to float datapath. Since the divisor is 2^k - 1, the quotient of
// a magnitude a < 2^k - 1 is the k-bit pattern of a repeated forever, so the
// significand is a window of that pattern; the tail never ends, so rounding
// is decided by the guard bit alone. Two stage registers, result combinational.
// ----------------------------------------------------------------------------
module nic_unpack (
  input  logic            clk,
  input  logic [31:0]     raw,
  input  nic_pkg::fmt_t   fmt,
  output nic_pkg::res_t   res
);
  import nic_pkg::*;

  logic        neg;
  logic [15:0] mag;
  ukind_t      kind;
  logic [15:0] mx;

  logic        neg1_r;
  logic [15:0] a1_r;
  ukind_t      kind1_r;
  fmt_t        fmt1_r;

  logic [3:0]  pos;
  logic [4:0]  lz;
  logic [63:0] rep;
  logic [69:0] rep7;
  logic [74:0] rep15;
  logic [63:0] shifted;

  logic        neg2_r;
  ukind_t      kind2_r;
  logic [7:0]  exp2_r;
  logic [24:0] win2_r;

  logic [30:0] mag_fp;

  // Decode sign and magnitude, classify
  always_comb begin
    neg = 1'b0;
    mag = 16'd0;
    case (fmt)
      FMT_U8:  mag = {8'd0, raw[7:0]};
      FMT_U16: mag = raw[15:0];
      FMT_S8: begin
        neg = raw[7];
        mag = raw[7] ? {8'd0, 8'(~raw[7:0] + 8'd1)} : {8'd0, raw[7:0]};
      end
      FMT_S16: begin
        neg = raw[15];
        mag = raw[15] ? 16'(~raw[15:0] + 16'd1) : raw[15:0];
      end
      default: mag = {8'd0, raw[7:0]};
    endcase
    mx = fmt_max(fmt);
    if (mag == 16'd0) begin
      kind = UK_ZERO;
    end else if (mag == mx) begin
      kind = UK_ONE;
    end else if (mag > mx) begin
      kind = UK_CLAMP;
    end else begin
      kind = UK_NORM;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r  <= neg;
    a1_r    <= mag;
    kind1_r <= kind;
    fmt1_r  <= fmt;
  end

  // Find leading one, build repeating pattern, align window
  always_comb begin
    pos = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (a1_r[i]) pos = 4'(i);
    end
    lz    = 5'(fmt_bits(fmt1_r) - 5'd1 - {1'b0, pos});
    rep7  = {10{a1_r[6:0]}};
    rep15 = {5{a1_r[14:0]}};
    case (fmt1_r)
      FMT_U8:  rep = {8{a1_r[7:0]}};
      FMT_U16: rep = {4{a1_r}};
      FMT_S8:  rep = rep7[69:6];
      FMT_S16: rep = rep15[74:11];
      default: rep = {8{a1_r[7:0]}};
    endcase
    shifted = rep << lz;
  end

  always_ff @(posedge clk) begin
    neg2_r  <= neg1_r;
    kind2_r <= kind1_r;
    exp2_r  <= 8'(8'd126 - {3'd0, lz});
    win2_r  <= shifted[63:39];
  end

  // Round on guard bit; carry runs into the exponent
  always_comb begin
    mag_fp  = {exp2_r, win2_r[23:1]} + {30'd0, win2_r[0]};
    res.sat = 1'b0;
    case (kind2_r)
      UK_ZERO:  res.raw = 32'd0;
      UK_ONE:   res.raw = {neg2_r, FP_ONE[30:0]};
      UK_CLAMP: res.raw = FP_NEG_ONE;
      UK_NORM:  res.raw = {neg2_r, mag_fp};
      default:  res.raw = 32'd0;
    endcase
  end

endmodule

// ===== rtl/nic_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_pack
// Float to integer datapath: significand times format maximum, round to a
// 24-bit single significand (nearest even), align to integer plus half bit,
// round half away from zero and saturate. Two stage registers, result
// combinational.
// ----------------------------------------------------------------------------
module nic_pack (
  input  logic            clk,
  input  logic [31:0]     raw,
  input  nic_pkg::fmt_t   fmt,
  output nic_pkg::res_t   res
);
  import nic_pkg::*;

  pkind_t      kind;

  logic        s1_r;
  logic [7:0]  e1_r;
  pkind_t      kind1_r;
  fmt_t        fmt1_r;
  logic [39:0] prod1_r;

  logic [4:0]  k;
  logic [5:0]  hi_idx;
  logic [4:0]  d;
  logic        lsb;
  logic        guard;
  logic        sticky;
  logic        up;
  logic [40:0] keep;
  logic [40:0] rnd;
  logic        huge;
  logic [7:0]  rsh;
  logic [40:0] t;

  logic        s2_r;
  pkind_t      kind2_r;
  fmt_t        fmt2_r;
  logic        ovf2_r;
  logic [17:0] n2_r;

  logic [17:0] mx;
  logic        is_signed;
  logic [17:0] mag_sel;
  logic        do_neg;
  logic [17:0] val;

  // Classify and multiply
  always_comb begin
    if (raw[30:23] == 8'hFF && raw[22:0] != 23'd0) begin
      kind = PK_NAN;
    end else if (raw[30:23] == 8'd0) begin
      kind = PK_ZERO;
    end else begin
      kind = PK_NORM;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= raw[31];
    e1_r    <= raw[30:23];
    kind1_r <= kind;
    fmt1_r  <= fmt;
    prod1_r <= 40'({1'b1, raw[22:0]}) * 40'(fmt_max(fmt));
  end

  // Round product to single, then align to integer and half bit
  always_comb begin
    k      = fmt_bits(fmt1_r);
    hi_idx = 6'd23 + {1'b0, k};
    d      = prod1_r[hi_idx] ? k : 5'(k - 5'd1);
    lsb    = prod1_r[d[5-1:0] + 5'd0];
    guard  = prod1_r[5'(d - 5'd1)];
    sticky = |(prod1_r & ((40'd1 << 5'(d - 5'd1)) - 40'd1));
    up     = guard & (sticky | lsb);
    keep   = {1'b0, prod1_r} >> d;
    rnd    = (keep + {40'd0, up}) << d;
    huge   = (e1_r >= 8'd149);
    rsh    = 8'(8'd149 - e1_r);
    t      = rnd >> rsh;
  end

  always_ff @(posedge clk) begin
    s2_r    <= s1_r;
    kind2_r <= kind1_r;
    fmt2_r  <= fmt1_r;
    ovf2_r  <= huge | (|t[40:18]);
    n2_r    <= {1'b0, t[17:1]} + {17'd0, t[0]};
  end

  // Saturate and encode
  always_comb begin
    mx        = {2'd0, fmt_max(fmt2_r)};
    is_signed = (fmt2_r == FMT_S8) || (fmt2_r == FMT_S16);
    mag_sel   = 18'd0;
    do_neg    = 1'b0;
    res.sat   = 1'b0;
    case (kind2_r)
      PK_NAN: begin
        res.sat = 1'b1;
      end
      PK_ZERO: begin
        mag_sel = 18'd0;
      end
      default: begin
        if (!s2_r) begin
          if (ovf2_r || n2_r > mx) begin
            mag_sel = mx;
            res.sat = 1'b1;
          end else begin
            mag_sel = n2_r;
          end
        end else if (is_signed) begin
          do_neg = 1'b1;
          if (ovf2_r || n2_r > 18'(mx + 18'd1)) begin
            mag_sel = 18'(mx + 18'd1);
            res.sat = 1'b1;
          end else begin
            mag_sel = n2_r;
          end
        end else begin
          res.sat = ovf2_r || (n2_r != 18'd0);
        end
      end
    endcase
    val = do_neg ? 18'(~mag_sel + 18'd1) : mag_sel;
    if (fmt2_r == FMT_U16 || fmt2_r == FMT_S16) begin
      res.raw = {16'd0, val[15:0]};
    end else begin
      res.raw = {24'd0, val[7:0]};
    end
  end

endmodule

// ===== rtl/normalized_int_float_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_int_float_converter
// Converts normalized 8/16-bit integers to IEEE singles and back, one
// element per clock through a three-stage pipeline.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | start / busy              | in_raw_in
//   result   | out_valid strobe          | out_raw_out, out_saturated
//   config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// An element accepted at one edge reaches the result ports through three
// register stages: multiply or decode, round and align, then saturate or
// encode plus the output register.
// A new element is taken every cycle; busy is always low.
// Reset clears the valid bits and both registers to zero.
// The receiver cannot stall, so nothing backs up into the pipeline.
// ----------------------------------------------------------------------------
module normalized_int_float_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   in_raw_in,
  output logic                          out_valid,
  output logic [31:0]                   out_raw_out,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import nic_pkg::*;

  fmt_t        fmt_r;
  logic        dir_r;
  logic        v1_r;
  logic        v2_r;
  logic        dir1_r;
  logic        dir2_r;
  logic        out_valid_r;
  logic [31:0] out_raw_r;
  logic        out_sat_r;
  logic        accept;
  res_t        up_res;
  res_t        pk_res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_U8;
      dir_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT:    fmt_r <= fmt_t'(cfg_data[1:0]);
        REG_DIRECTION: dir_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  nic_unpack u_unpack (
    .clk (clk),
    .raw (in_raw_in),
    .fmt (fmt_r),
    .res (up_res)
  );

  nic_pack u_pack (
    .clk (clk),
    .raw (in_raw_in),
    .fmt (fmt_r),
    .res (pk_res)
  );

  // Advance valid bits with the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Carry direction alongside, select result
  always_ff @(posedge clk) begin
    dir1_r    <= dir_r;
    dir2_r    <= dir1_r;
    out_raw_r <= dir2_r ? pk_res.raw : up_res.raw;
    out_sat_r <= dir2_r ? pk_res.sat : up_res.sat;
  end

  assign out_valid     = out_valid_r;
  assign out_raw_out   = out_raw_r;
  assign out_saturated = out_sat_r;

  // Every result beat stems from a matching start beat earlier in the pipeline
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result beat without matching input beat");

  // The flag is only raised on a pack beat
  a_sat_pack : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> $past(v2_r && dir2_r))
    else $error("saturation flag on an unpack beat");

endmodule

// ===== test/tb_normalized_int_float_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normalized_int_float_converter
// Self-checking bench for the normalized integer / IEEE single converter.
// A behavioral predictor, built on double-precision reals with explicit
// rounding to single, computes each element's result when the element is
// accepted. A monitor compares every result strobe against the oldest
// prediction. Directed unpack and pack tests come first, then random
// elements over many format and direction settings, with random gaps on
// the start line.
// ----------------------------------------------------------------------------
module tb_normalized_int_float_converter;
  import nic_pkg::*;

  typedef struct {
    logic [31:0] raw;
    logic        sat;
  } conv_res_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_raw_in = '0;
  logic        out_valid;
  logic [31:0] out_raw_out;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  conv_res_t pending_results[$];
  fmt_t      cur_format = FMT_U8;
  logic      cur_pack = 1'b0;
  bit        gaps_on = 1'b1;
  int        error_count = 0;
  int        beats_sent = 0;
  int        beats_checked = 0;
  int        cycle_count = 0;

  normalized_int_float_converter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_raw_in    (in_raw_in),
    .out_valid    (out_valid),
    .out_raw_out  (out_raw_out),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Format tables
  function automatic int fmt_top(fmt_t f);
    case (f)
      FMT_U8:  return 255;
      FMT_U16: return 65535;
      FMT_S8:  return 127;
      default: return 32767;
    endcase
  endfunction

  function automatic int fmt_bottom(fmt_t f);
    case (f)
      FMT_S8:  return -128;
      FMT_S16: return -32768;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] fmt_mask(fmt_t f);
    return (f == FMT_U8 || f == FMT_S8) ? 32'hFF : 32'hFFFF;
  endfunction

  // Round a double to the nearest single, ties to even
  function automatic logic [31:0] to_single(real v);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] r;
    int e;
    int se;
    int sh;
    d = $realtobits(v);
    e = int'(d[62:52]);
    if (e == 2047) return {d[63], 8'hFF, 23'h0};
    if (e == 0) return {d[63], 31'h0};
    se = e - 1023 + 127;
    if (se >= 255) return {d[63], 8'hFF, 23'h0};
    sig = {11'h0, 1'b1, d[51:0]};
    sh = (se >= 1) ? 29 : 29 + 1 - se;
    if (sh >= 60) return {d[63], 31'h0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    // a carry out of the mantissa bumps the exponent, possibly to infinity
    if (se >= 1) r = (32'(se) << 23) + q[31:0] - 32'h0080_0000;
    else r = q[31:0];
    return {d[63], r[30:0]};
  endfunction

  function automatic real from_single(logic [31:0] b);
    real m;
    if (b[30:23] == 8'hFF)
      return $bitstoreal({b[31], 11'h7FF, 52'h0});
    if (b[30:23] == 8'h00) begin
      m = real'(b[22:0]) * (2.0 ** (-149));
      return b[31] ? -m : m;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0});
  endfunction

  // Expected result of one element under the current settings
  function automatic conv_res_t convert_element(logic [31:0] raw);
    conv_res_t r;
    logic [31:0] v;
    int x;
    int n;
    real p;
    real top;
    top = real'(fmt_top(cur_format));
    r.sat = 1'b0;
    if (!cur_pack) begin
      v = raw & fmt_mask(cur_format);
      x = int'(v);
      if (cur_format == FMT_S8 && v[7]) x = x - 256;
      if (cur_format == FMT_S16 && v[15]) x = x - 65536;
      if (x < -fmt_top(cur_format)) r.raw = FP_NEG_ONE;
      else r.raw = to_single(real'(x) / top);
    end else if (raw[30:23] == 8'hFF && raw[22:0] != 0) begin
      r.sat = 1'b1;
      r.raw = '0;
    end else begin
      p = from_single(to_single(from_single(raw) * top));
      if (p >= top + 0.5) begin
        r.sat = 1'b1;
        n = fmt_top(cur_format);
      end else if (p <= real'(fmt_bottom(cur_format)) - 0.5) begin
        r.sat = 1'b1;
        n = fmt_bottom(cur_format);
      end else if (p < 0.0) begin
        n = -$rtoi(-p + 0.5);
      end else begin
        n = $rtoi(p + 0.5);
      end
      r.raw = 32'(n) & fmt_mask(cur_format);
    end
    return r;
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    conv_res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: raw_out=%h", out_raw_out);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (out_raw_out !== e.raw) begin
          $error("raw_out: expected %h, actual %h", e.raw, out_raw_out);
          error_count++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %b, actual %b", e.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // Offer one element; start stays high so back-to-back beats are possible
  task automatic send_item(logic [31:0] raw);
    while (gaps_on && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_raw_in <= raw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(convert_element(raw));
    beats_sent++;
  endtask

  // Drop start, drain the pipeline, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FORMAT) cur_format = fmt_t'(data[1:0]);
    else if (idx == REG_DIRECTION) cur_pack = data[0];
  endtask

  task automatic set_mode(fmt_t f, logic pack);
    write_reg(REG_FORMAT, {30'h0, f});
    write_reg(REG_DIRECTION, {31'h0, pack});
  endtask

  // Codes at the format edges, with junk above the format width
  task automatic test_unpack_directed();
    fmt_t f;
    for (int i = 0; i < 4; i++) begin
      f = fmt_t'(i);
      set_mode(f, 1'b0);
      send_item(32'h0);
      send_item(32'h1);
      send_item(32'(fmt_top(f)));
      send_item(32'(fmt_bottom(f)) & fmt_mask(f));
      send_item(32'(-fmt_top(f)) & fmt_mask(f));
      send_item(32'hFFFF_FFFF);
      send_item(32'hA5A5_0000 | 32'h3);
    end
  endtask

  // NaN, infinities, signed zero, halves, overflow and subnormals
  task automatic test_pack_directed();
    real top;
    set_mode(FMT_U8, 1'b1);
    send_item(32'h7FC0_0000);
    send_item(32'hFF80_0001);
    send_item(32'h7F80_0000);
    send_item(32'hFF80_0000);
    send_item(32'h8000_0000);
    send_item(32'h0000_0000);
    send_item(32'h0000_0001);
    send_item(FP_ONE);
    send_item(FP_NEG_ONE);
    send_item(32'h7F7F_FFFF);
    set_mode(FMT_S16, 1'b1);
    top = 32767.0;
    send_item(to_single(0.5 / top));
    send_item(to_single(-0.5 / top));
    send_item(to_single(-32768.5 / top));
    send_item(to_single(-32768.0 / top));
    send_item(to_single(32767.5 / top));
    send_item(FP_NEG_ONE);
  endtask

  // Random elements over a series of settings
  task automatic test_random();
    fmt_t f;
    logic pack;
    int top;
    int lo;
    real v;
    logic [31:0] b;
    for (int ph = 0; ph < 12; ph++) begin
      f = (ph >= 8) ? fmt_t'($urandom_range(0, 3)) : fmt_t'(ph % 4);
      pack = (ph >= 8) ? 1'($urandom_range(0, 1)) : 1'(ph / 4);
      // invalid index and high data bits must be ignored
      write_reg(8'd2 + 8'($urandom_range(0, 200)), $urandom);
      write_reg(REG_FORMAT, {30'($urandom), 2'b00} | 32'(f));
      write_reg(REG_DIRECTION, {31'($urandom), 1'b0} | 32'(pack));
      gaps_on = (ph != 5);
      top = fmt_top(cur_format);
      lo = fmt_bottom(cur_format);
      for (int i = 0; i < 125; i++) begin
        if (!cur_pack || $urandom_range(0, 3) == 0) begin
          b = $urandom;
        end else begin
          // half-integer products near every code, with an ulp of jitter
          v = (real'($urandom_range(0, 2 * (top - lo) + 8)) / 2.0 + real'(lo) - 2.0)
              / real'(top);
          b = to_single(v) + 32'($urandom_range(0, 2)) - 32'd1;
        end
        send_item(b);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unpack_directed();
    test_pack_directed();
    test_random();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Sent %0d elements across all four formats in both directions;", beats_sent);
    $display("%0d result beats compared.", beats_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== normalized_int_float_converter.f =====
rtl/nic_pkg.sv
rtl/nic_unpack.sv
rtl/nic_pack.sv
rtl/normalized_int_float_converter.sv
test/tb_normalized_int_float_converter.sv
